[rtl/core/rsame_pkg.sv]
// Shared constants and transaction types for the RSA modular exponentiation block.
package rsame_pkg;

  localparam int MOD_BITS = 31;
  localparam int CNT_W    = $clog2(MOD_BITS);
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;
  localparam int REG_IW   = 2;

  localparam logic [REG_IW-1:0] REG_MODULUS  = 2'd0;
  localparam logic [REG_IW-1:0] REG_PUB_EXP  = 2'd1;
  localparam logic [REG_IW-1:0] REG_PRIV_EXP = 2'd2;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic                op;
    logic [MOD_BITS-1:0] value;
    logic                end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] residue;
    logic                last;
  } out_item_t;

endpackage

[rtl/core/rsa_modular_exponentiation.sv]
// Top level: right-to-left square-and-multiply modexp over one shared shift-add modmul unit.
// Sequence after accept: base reduction, then per exponent bit up to its top set bit a dispatch
//   state plus a multiply (bit set) and a square, then a final dispatch and the output register.
// Modulus below 2: skips the arithmetic and returns residue 0. One transaction in flight; input
//   ready returns as the result registers. Reset: async, active low; modulus 2, both exponents 0.
module rsa_modular_exponentiation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rsame_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rsame_pkg::out_item_t          out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsame_pkg::APB_AW-1:0]  paddr,
  input  logic [rsame_pkg::APB_DW-1:0]  pwdata,
  output logic [rsame_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import rsame_pkg::*;

  localparam int W  = MOD_BITS;
  localparam int SW = MOD_BITS + 3;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_DISP   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_SQR    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [W-1:0]      modulus_q, pub_exp_q, priv_exp_q;
  logic [2:0]        state_q, state_d;
  logic [W-1:0]      exp_q, exp_d;
  logic [W-1:0]      b_q, b_d;
  logic [W-1:0]      acc_q, acc_d;
  logic [W-1:0]      mx_q, mx_d;
  logic [W-1:0]      my_q, my_d;
  logic [W-1:0]      macc_q, macc_d;
  logic [CNT_W-1:0]  mcnt_q, mcnt_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic [SW-1:0]     sum, diff1, diff2;
  logic [W-1:0]      step;
  logic              mul_last;
  logic              cfg_wr;
  logic [REG_IW-1:0] reg_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  always_comb begin
    unique case (reg_idx)
      REG_MODULUS:  prdata = APB_DW'(modulus_q);
      REG_PUB_EXP:  prdata = APB_DW'(pub_exp_q);
      REG_PRIV_EXP: prdata = APB_DW'(priv_exp_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= W'(2);
      pub_exp_q  <= '0;
      priv_exp_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODULUS:  modulus_q  <= pwdata[W-1:0];
        REG_PUB_EXP:  pub_exp_q  <= pwdata[W-1:0];
        REG_PRIV_EXP: priv_exp_q <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Shared modmul step: acc = 2*acc + xbit*y, reduced below m (y < m, acc < m)
  always_comb begin
    sum   = {2'b00, macc_q, 1'b0} + (mx_q[W-1] ? {3'b000, my_q} : '0);
    diff1 = sum - {3'b000, modulus_q};
    diff2 = sum - {2'b00, modulus_q, 1'b0};
    priority if (!diff2[SW-1]) begin
      step = diff2[W-1:0];
    end else if (!diff1[SW-1]) begin
      step = diff1[W-1:0];
    end else begin
      step = sum[W-1:0];
    end
  end

  assign mul_last = (mcnt_q == CNT_W'(MOD_BITS - 1));

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    b_d         = b_q;
    acc_d       = acc_q;
    mx_d        = mx_q;
    my_d        = my_q;
    macc_d      = macc_q;
    mcnt_d      = mcnt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = in_data_i.end_of_message;
          exp_d  = (in_data_i.op == OP_DECRYPT) ? priv_exp_q : pub_exp_q;
          if (modulus_q < W'(2)) begin
            acc_d   = '0;
            state_d = S_DONE;
          end else begin
            mx_d    = in_data_i.value;
            my_d    = W'(1);
            macc_d  = '0;
            mcnt_d  = '0;
            state_d = S_REDUCE;
          end
        end
      end
      S_REDUCE, S_MUL, S_SQR: begin
        macc_d = step;
        mx_d   = mx_q << 1;
        mcnt_d = mcnt_q + CNT_W'(1);
        if (mul_last) begin
          unique case (state_q)
            S_REDUCE: begin
              b_d     = step;
              acc_d   = W'(1);
              state_d = S_DISP;
            end
            S_MUL: begin
              acc_d   = step;
              mx_d    = b_q;
              my_d    = b_q;
              macc_d  = '0;
              mcnt_d  = '0;
              state_d = S_SQR;
            end
            default: begin
              b_d     = step;
              exp_d   = exp_q >> 1;
              state_d = S_DISP;
            end
          endcase
        end
      end
      S_DISP: begin
        if (exp_q == '0) begin
          state_d = S_DONE;
        end else begin
          macc_d = '0;
          mcnt_d = '0;
          my_d   = b_q;
          if (exp_q[0]) begin
            mx_d    = acc_q;
            state_d = S_MUL;
          end else begin
            mx_d    = b_q;
            state_d = S_SQR;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_data_d.residue = acc_q;
          out_data_d.last    = last_q;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q      <= exp_d;
    b_q        <= b_d;
    acc_q      <= acc_d;
    mx_q       <= mx_d;
    my_q       <= my_d;
    macc_q     <= macc_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/rsame_checker.sv]
// Port-level checker for the RSA modular exponentiation block, bound to the top level.
module rsame_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input rsame_pkg::out_item_t          out_data_o,
  input logic                          pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // one transaction in flight
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous transaction still in work");

  // a new result only appears after the engine was busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a transaction in work");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("config port stalled");

endmodule

bind rsa_modular_exponentiation rsame_checker u_rsame_checker (.*);

[tb/tb_rsa_modular_exponentiation.sv]
// Self-checking testbench for the RSA modular exponentiation block: directed and random modexp traffic.
`timescale 1ns / 100ps

module tb_rsa_modular_exponentiation;
  import rsame_pkg::*;

  localparam int          CLK_HALF      = 4;
  localparam int          RESET_CYCLES  = 7;
  localparam int          IDLE_PCT      = 21;
  localparam int          RANDOM_PHASES = 10;
  localparam int          PHASE_ITEMS   = 29;
  localparam int          DRAIN_CYCLES  = 2100;
  localparam longint      CYCLE_LIMIT   = 3_000_000;
  localparam logic [REG_IW-1:0]   REG_UNUSED = 2'd3;
  localparam logic [MOD_BITS-1:0] VALUE_MAX  = '1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [APB_AW-1:0]    paddr       = '0;
  logic [APB_DW-1:0]    pwdata      = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // register copies used by the predictor
  logic [MOD_BITS-1:0]  modulus_cfg  = MOD_BITS'(2);
  logic [MOD_BITS-1:0]  pub_exp_cfg  = '0;
  logic [MOD_BITS-1:0]  priv_exp_cfg = '0;

  in_item_t             pending_items[$];
  out_item_t            expected_residues[$];
  logic                 in_gaps_on  = 1'b1;
  logic                 out_gaps_on = 1'b1;
  int                   error_count     = 0;
  int                   results_checked = 0;
  int                   encrypt_count   = 0;
  int                   decrypt_count   = 0;
  int                   setting_count   = 0;
  longint               cycle_count     = 0;

  rsa_modular_exponentiation DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // right-to-left square-and-multiply, exact in 64 bits for a 31-bit modulus
  function automatic logic [MOD_BITS-1:0] modexp_residue(input logic [MOD_BITS-1:0] base,
                                                         input logic [MOD_BITS-1:0] expo,
                                                         input logic [MOD_BITS-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m64;
    acc = 64'd1;
    sq  = 64'(base);
    m64 = 64'(m);
    if (m64 < 64'd2) return '0;
    sq = sq % m64;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (expo[i]) acc = (acc * sq) % m64;
      sq = (sq * sq) % m64;
    end
    return acc[MOD_BITS-1:0];
  endfunction

  // driver
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        exp_item.residue = modexp_residue(in_data_i.value,
                                          (in_data_i.op == OP_DECRYPT) ? priv_exp_cfg
                                                                       : pub_exp_cfg,
                                          modulus_cfg);
        exp_item.last    = in_data_i.end_of_message;
        expected_residues.push_back(exp_item);
        if (in_data_i.op == OP_DECRYPT) decrypt_count++;
        else encrypt_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 &&
            !(in_gaps_on && $urandom_range(99) < IDLE_PCT)) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_residues.size() == 0) begin
          $display("%0t: unexpected result residue=%0d last=%0b", $time,
                   out_data_o.residue, out_data_o.last);
          error_count++;
        end else begin
          exp_item = expected_residues.pop_front();
          results_checked++;
          if (out_data_o.residue !== exp_item.residue) begin
            $display("%0t: residue mismatch: expected %0d, actual %0d", $time,
                     exp_item.residue, out_data_o.residue);
            error_count++;
          end
          if (out_data_o.last !== exp_item.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b", $time,
                     exp_item.last, out_data_o.last);
            error_count++;
          end
        end
      end
      out_ready_i <= !(out_gaps_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_residues.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_item(input logic op, input logic [MOD_BITS-1:0] value,
                            input logic eom);
    in_item_t item;
    item.op             = op;
    item.value          = value;
    item.end_of_message = eom;
    pending_items.push_back(item);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_residues.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODULUS:  modulus_cfg  = data[MOD_BITS-1:0];
      REG_PUB_EXP:  pub_exp_cfg  = data[MOD_BITS-1:0];
      REG_PRIV_EXP: priv_exp_cfg = data[MOD_BITS-1:0];
      default: ;
    endcase
    setting_count++;
  endtask

  function automatic logic [MOD_BITS-1:0] random_width(input int w);
    if (w == 0) return '0;
    return MOD_BITS'($urandom() & ((33'h1 << w) - 1));
  endfunction

  initial begin
    logic [MOD_BITS-1:0] m;
    int                  w;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: modulus 2, zero exponents
    queue_item(OP_ENCRYPT, '0, 1'b0);
    queue_item(OP_DECRYPT, VALUE_MAX, 1'b1);
    queue_item(OP_ENCRYPT, MOD_BITS'(5), 1'b0);
    wait_drained();

    // largest modulus, top bit of write data dropped; full public exponent, zero private
    write_reg(REG_MODULUS, 32'hFFFF_FFFF);
    write_reg(REG_PUB_EXP, 32'h7FFF_FFFF);
    write_reg(REG_PRIV_EXP, 32'h0000_0000);
    queue_item(OP_ENCRYPT, '0, 1'b0);
    queue_item(OP_ENCRYPT, MOD_BITS'(1), 1'b0);
    queue_item(OP_ENCRYPT, VALUE_MAX, 1'b0);
    queue_item(OP_ENCRYPT, VALUE_MAX - 1, 1'b1);
    queue_item(OP_DECRYPT, MOD_BITS'(12345), 1'b0);
    queue_item(OP_DECRYPT, VALUE_MAX, 1'b1);
    wait_drained();

    // textbook key pair, values below and above the modulus
    write_reg(REG_MODULUS, 32'd3233);
    write_reg(REG_PUB_EXP, 32'd17);
    write_reg(REG_PRIV_EXP, 32'd2753);
    queue_item(OP_ENCRYPT, MOD_BITS'(65), 1'b0);
    queue_item(OP_DECRYPT, MOD_BITS'(2790), 1'b1);
    queue_item(OP_ENCRYPT, MOD_BITS'(3233 + 65), 1'b0);
    queue_item(OP_DECRYPT, VALUE_MAX, 1'b1);
    wait_drained();

    // write outside the register map has no effect
    write_reg(REG_UNUSED, 32'h0000_0005);
    queue_item(OP_ENCRYPT, MOD_BITS'(65), 1'b1);
    wait_drained();

    write_reg(REG_PRIV_EXP, 32'hFFFF_FFFF);
    queue_item(OP_DECRYPT, MOD_BITS'(100), 1'b0);
    queue_item(OP_ENCRYPT, '0, 1'b1);
    wait_drained();

    // degenerate moduli
    write_reg(REG_MODULUS, 32'd0);
    queue_item(OP_ENCRYPT, MOD_BITS'(7), 1'b0);
    queue_item(OP_DECRYPT, VALUE_MAX, 1'b1);
    wait_drained();
    write_reg(REG_MODULUS, 32'd1);
    queue_item(OP_ENCRYPT, '0, 1'b0);
    queue_item(OP_DECRYPT, MOD_BITS'(9), 1'b1);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_gaps_on  <= (p != 3);
      out_gaps_on <= (p != 3);
      case ($urandom_range(9))
        0: m = MOD_BITS'($urandom_range(1));
        1: m = VALUE_MAX;
        default: begin
          w = $urandom_range(2, MOD_BITS);
          m = random_width(w) | (MOD_BITS'(1) << (w - 1));
        end
      endcase
      write_reg(REG_MODULUS, {1'($urandom_range(1)), m});
      if (p == RANDOM_PHASES - 1) begin
        write_reg(REG_PUB_EXP, {1'($urandom_range(1)), VALUE_MAX});
        write_reg(REG_PRIV_EXP, {1'($urandom_range(1)), VALUE_MAX});
      end else begin
        write_reg(REG_PUB_EXP,
                  {1'($urandom_range(1)), random_width($urandom_range(0, MOD_BITS))});
        write_reg(REG_PRIV_EXP,
                  {1'($urandom_range(1)), random_width($urandom_range(0, MOD_BITS))});
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(1) == 0 || m < 2)
          queue_item(1'($urandom_range(1)), MOD_BITS'($urandom()),
                     ($urandom_range(5) == 0) || (k == PHASE_ITEMS - 1));
        else
          queue_item(1'($urandom_range(1)), MOD_BITS'($urandom_range(32'(m) - 1)),
                     ($urandom_range(5) == 0) || (k == PHASE_ITEMS - 1));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_residues.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_residues.size());
      error_count++;
    end
    $display("checked %0d results (%0d encrypt, %0d decrypt) across %0d register writes",
             results_checked, encrypt_count, decrypt_count, setting_count);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
